@@ hw/rtl/rtcs_pkg.sv @@
package rtcs_pkg;

  // Command codes carried on the opcode field.
  localparam logic [2:0] OP_READ_TIME       = 3'd0;
  localparam logic [2:0] OP_SET_TIME        = 3'd1;
  localparam logic [2:0] OP_START           = 3'd2;
  localparam logic [2:0] OP_START_IF_HALTED = 3'd3;
  localparam logic [2:0] OP_QUERY           = 3'd4;
  localparam logic [2:0] OP_REPLY           = 3'd5;

  // Result kinds.
  localparam logic [1:0] K_WRITE  = 2'd0;
  localparam logic [1:0] K_READ   = 2'd1;
  localparam logic [1:0] K_REPORT = 2'd2;
  localparam logic [1:0] K_STATUS = 2'd3;

  // Device command bytes; the low bit selects a read.
  localparam logic [7:0] REG_SEC_WR  = 8'h80;
  localparam logic [7:0] REG_SEC_RD  = 8'h81;
  localparam logic [7:0] REG_MIN_WR  = 8'h82;
  localparam logic [7:0] REG_MIN_RD  = 8'h83;
  localparam logic [7:0] REG_HOUR_WR = 8'h84;
  localparam logic [7:0] REG_HOUR_RD = 8'h85;
  localparam logic [7:0] REG_DAY_WR  = 8'h86;
  localparam logic [7:0] REG_DAY_RD  = 8'h87;
  localparam logic [7:0] REG_MON_WR  = 8'h88;
  localparam logic [7:0] REG_MON_RD  = 8'h89;
  localparam logic [7:0] REG_WDAY_WR = 8'h8A;
  localparam logic [7:0] REG_YEAR_WR = 8'h8C;
  localparam logic [7:0] REG_YEAR_RD = 8'h8D;
  localparam logic [7:0] REG_WP_WR   = 8'h8E;

  localparam logic [7:0] WP_OFF   = 8'h00;
  localparam logic [7:0] WP_ON    = 8'h80;
  localparam logic [7:0] WDAY_VAL = 8'h01;

  localparam logic [11:0] YEAR_BASE = 12'd2000;
  localparam logic [15:0] YEAR_MIN  = 16'd2000;
  localparam logic [15:0] YEAR_MAX  = 16'd2099;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int STEP_W          = 4;

  typedef enum logic [4:0] {
    JOB_STATUS = 5'b00001,
    JOB_READ   = 5'b00010,
    JOB_REPORT = 5'b00100,
    JOB_START  = 5'b01000,
    JOB_SET    = 5'b10000
  } job_kind_t;

  // One classified command, handed from the front end to the back end.
  typedef struct packed {
    job_kind_t   kind;
    logic        ok;
    logic        running;
    logic        has_write;
    logic [7:0]  addr;
    logic [7:0]  wr_data;
    logic [7:0]  sec_bcd;
    logic [7:0]  min_bcd;
    logic [7:0]  hour_bcd;
    logic [7:0]  day_bcd;
    logic [7:0]  mon_bcd;
    logic [7:0]  year_bcd;
    logic [6:0]  second;
    logic [6:0]  minute;
    logic [5:0]  hour;
    logic [5:0]  day;
    logic [4:0]  month;
    logic [11:0] year;
  } job_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  bus_command;
    logic [7:0]  bus_data;
    logic [6:0]  second;
    logic [6:0]  minute;
    logic [5:0]  hour;
    logic [5:0]  day;
    logic [4:0]  month;
    logic [11:0] year;
    logic        ok;
    logic        running;
    logic        last;
  } result_t;

  // Read command for the register at position idx of the read-time sequence.
  function automatic logic [7:0] rd_addr(input logic [2:0] idx);
    logic [7:0] a;
    case (idx)
      3'd0:    a = REG_SEC_RD;
      3'd1:    a = REG_MIN_RD;
      3'd2:    a = REG_HOUR_RD;
      3'd3:    a = REG_DAY_RD;
      3'd4:    a = REG_MON_RD;
      default: a = REG_YEAR_RD;
    endcase
    return a;
  endfunction

  // Binary 0..99 to packed BCD; tens come from a multiply by 205/2048.
  function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - ({tens, 3'b000} + {2'b00, tens, 1'b0});
    return {tens, ones[3:0]};
  endfunction

  // Packed BCD to binary; digits above nine decode as high*10+low.
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    return 8'({v[7:4], 3'b000}) + 8'({v[7:4], 1'b0}) + 8'(v[3:0]);
  endfunction

endpackage

@@ hw/rtl/rtcs_front.sv @@
module rtcs_front
  import rtcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        q_ready,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_set_year,
  input  logic [7:0]  in_set_month,
  input  logic [7:0]  in_set_day,
  input  logic [7:0]  in_set_hour,
  input  logic [7:0]  in_set_minute,
  input  logic [7:0]  in_set_second,
  input  logic [7:0]  in_reply_byte,
  output logic        push,
  output job_t        job
);

  typedef enum logic [4:0] {
    PEND_NONE     = 5'b00001,
    PEND_READ     = 5'b00010,
    PEND_START    = 5'b00100,
    PEND_START_IF = 5'b01000,
    PEND_QUERY    = 5'b10000
  } pend_t;

  pend_t      pend_r, pend_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [6:0] sec_r, sec_nxt;
  logic [6:0] min_r, min_nxt;
  logic [5:0] hour_r, hour_nxt;
  logic [5:0] day_r, day_nxt;
  logic [4:0] mon_r, mon_nxt;

  logic        range_ok;
  logic [6:0]  year_off;
  logic [7:0]  d_sec, d_min, d_hour, d_day, d_mon;

  assign push = in_valid && q_ready;

  // Only meaningful once the range check has passed, so the year is 2000..2099.
  assign year_off = 7'(in_set_year - YEAR_MIN);
  assign range_ok = (in_set_year >= YEAR_MIN) && (in_set_year <= YEAR_MAX) &&
                    (in_set_month >= 8'd1) && (in_set_month <= 8'd12) &&
                    (in_set_day >= 8'd1) && (in_set_day <= 8'd31) &&
                    (in_set_hour <= 8'd23) && (in_set_minute <= 8'd59) &&
                    (in_set_second <= 8'd59);

  assign d_sec  = bcd_to_bin({1'b0, sec_r});
  assign d_min  = bcd_to_bin({1'b0, min_r});
  assign d_hour = bcd_to_bin({2'b00, hour_r});
  assign d_day  = bcd_to_bin({2'b00, day_r});
  assign d_mon  = bcd_to_bin({3'b000, mon_r});

  always_comb begin
    pend_nxt = pend_r;
    idx_nxt  = idx_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    day_nxt  = day_r;
    mon_nxt  = mon_r;
    job      = '0;
    job.kind = JOB_STATUS;
    if (in_opcode == OP_REPLY) begin
      unique case (pend_r)
        PEND_READ: begin
          if (idx_r < 3'd5) begin
            job.kind = JOB_READ;
            job.addr = rd_addr(idx_r + 3'd1);
            idx_nxt  = idx_r + 3'd1;
            case (idx_r)
              3'd0:    sec_nxt  = in_reply_byte[6:0];
              3'd1:    min_nxt  = in_reply_byte[6:0];
              3'd2:    hour_nxt = in_reply_byte[5:0];
              3'd3:    day_nxt  = in_reply_byte[5:0];
              default: mon_nxt  = in_reply_byte[4:0];
            endcase
          end else begin
            job.kind   = JOB_REPORT;
            job.second = d_sec[6:0];
            job.minute = d_min[6:0];
            job.hour   = d_hour[5:0];
            job.day    = d_day[5:0];
            job.month  = d_mon[4:0];
            job.year   = YEAR_BASE + 12'(bcd_to_bin(in_reply_byte));
            job.ok     = (d_mon >= 8'd1) && (d_mon <= 8'd12) && (d_day >= 8'd1) &&
                         (d_day <= 8'd31) && (d_hour <= 8'd23) && (d_min <= 8'd59) &&
                         (d_sec <= 8'd59);
            pend_nxt   = PEND_NONE;
            idx_nxt    = 3'd0;
          end
        end
        PEND_START: begin
          job.kind      = JOB_START;
          job.has_write = 1'b1;
          job.wr_data   = {1'b0, in_reply_byte[6:0]};
          job.ok        = 1'b1;
          pend_nxt      = PEND_NONE;
        end
        PEND_START_IF: begin
          job.kind      = JOB_START;
          job.has_write = in_reply_byte[7];
          job.wr_data   = {1'b0, in_reply_byte[6:0]};
          job.ok        = 1'b1;
          job.running   = !in_reply_byte[7];
          pend_nxt      = PEND_NONE;
        end
        PEND_QUERY: begin
          job.ok      = 1'b1;
          job.running = !in_reply_byte[7];
          pend_nxt    = PEND_NONE;
        end
        default: begin
          pend_nxt = PEND_NONE;
        end
      endcase
    end else if (in_opcode > OP_REPLY || pend_r != PEND_NONE) begin
      job.kind = JOB_STATUS;
    end else if (in_opcode == OP_SET_TIME) begin
      if (range_ok) begin
        job.kind     = JOB_SET;
        job.ok       = 1'b1;
        job.sec_bcd  = bin_to_bcd(in_set_second[6:0]);
        job.min_bcd  = bin_to_bcd(in_set_minute[6:0]);
        job.hour_bcd = bin_to_bcd(in_set_hour[6:0]);
        job.day_bcd  = bin_to_bcd(in_set_day[6:0]);
        job.mon_bcd  = bin_to_bcd(in_set_month[6:0]);
        job.year_bcd = bin_to_bcd(year_off);
      end
    end else begin
      job.kind = JOB_READ;
      job.addr = REG_SEC_RD;
      idx_nxt  = 3'd0;
      case (in_opcode)
        OP_START:           pend_nxt = PEND_START;
        OP_START_IF_HALTED: pend_nxt = PEND_START_IF;
        OP_QUERY:           pend_nxt = PEND_QUERY;
        default:            pend_nxt = PEND_READ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      idx_r  <= 3'd0;
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
      day_r  <= '0;
      mon_r  <= '0;
    end else if (push) begin
      pend_r <= pend_nxt;
      idx_r  <= idx_nxt;
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      day_r  <= day_nxt;
      mon_r  <= mon_nxt;
    end
  end

endmodule

@@ hw/rtl/rtcs_queue.sv @@
module rtcs_queue
  import rtcs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic can_push,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  job_t          slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign can_push   = (count_r != FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/rtcs_back.sv @@
module rtcs_back
  import rtcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    head_valid,
  input  job_t    head_job,
  output logic    pop,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] final_step;
  logic              is_final;
  logic              load;
  logic              out_valid_r;
  result_t           out_res_r;
  result_t           res;

  always_comb begin
    case (head_job.kind)
      JOB_SET:   final_step = STEP_W'(9);
      JOB_START: final_step = head_job.has_write ? STEP_W'(1) : STEP_W'(0);
      default:   final_step = STEP_W'(0);
    endcase
  end

  assign is_final = (step_r == final_step);
  assign load     = head_valid && (!out_valid_r || out_ready);
  assign pop      = load && is_final;

  always_comb begin
    res      = '0;
    res.kind = K_STATUS;
    unique case (head_job.kind)
      JOB_STATUS: begin
        res.ok      = head_job.ok;
        res.running = head_job.running;
      end
      JOB_READ: begin
        res.kind        = K_READ;
        res.bus_command = head_job.addr;
      end
      JOB_REPORT: begin
        res.kind   = K_REPORT;
        res.second = head_job.second;
        res.minute = head_job.minute;
        res.hour   = head_job.hour;
        res.day    = head_job.day;
        res.month  = head_job.month;
        res.year   = head_job.year;
        res.ok     = head_job.ok;
      end
      JOB_START: begin
        if (head_job.has_write && step_r == '0) begin
          res.kind        = K_WRITE;
          res.bus_command = REG_SEC_WR;
          res.bus_data    = head_job.wr_data;
        end else begin
          res.ok      = head_job.ok;
          res.running = head_job.running;
        end
      end
      JOB_SET: begin
        res.kind = K_WRITE;
        case (step_r)
          STEP_W'(0): begin
            res.bus_command = REG_WP_WR;
            res.bus_data    = WP_OFF;
          end
          STEP_W'(1): begin
            res.bus_command = REG_SEC_WR;
            res.bus_data    = {1'b0, head_job.sec_bcd[6:0]};
          end
          STEP_W'(2): begin
            res.bus_command = REG_MIN_WR;
            res.bus_data    = head_job.min_bcd;
          end
          STEP_W'(3): begin
            res.bus_command = REG_HOUR_WR;
            res.bus_data    = head_job.hour_bcd;
          end
          STEP_W'(4): begin
            res.bus_command = REG_DAY_WR;
            res.bus_data    = head_job.day_bcd;
          end
          STEP_W'(5): begin
            res.bus_command = REG_MON_WR;
            res.bus_data    = head_job.mon_bcd;
          end
          STEP_W'(6): begin
            res.bus_command = REG_WDAY_WR;
            res.bus_data    = WDAY_VAL;
          end
          STEP_W'(7): begin
            res.bus_command = REG_YEAR_WR;
            res.bus_data    = head_job.year_bcd;
          end
          STEP_W'(8): begin
            res.bus_command = REG_WP_WR;
            res.bus_data    = WP_ON;
          end
          default: begin
            res.kind = K_STATUS;
            res.ok   = 1'b1;
          end
        endcase
      end
      default: begin
        res.kind = K_STATUS;
      end
    endcase
    res.last = is_final;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      step_r      <= is_final ? '0 : step_r + STEP_W'(1);
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ hw/rtl/rtc_time_register_sequencer.sv @@
// Channel   Direction  Handshake             Contents
// in_*      input      in_valid / in_ready   one request: opcode, set-time fields, reply byte
// out_*     output     out_valid / out_ready one result: bus write, bus read, report or status
//
// The front end takes one request per cycle while the job queue has room; it
// is accepted at an edge where in_valid and in_ready are both high.
// The back end sends one result per cycle while a job is queued and out_ready
// is high: one result for most requests, two for a start that writes, ten for
// set time. With the queue empty and the output free, an accepted request goes
// into the queue, then its first result is loaded into the output register.
// Reset (rst_n low, synchronous) empties the queue and the output register and
// clears the pending read; out_ready low holds the output and backs up the queue.
module rtc_time_register_sequencer
  import rtcs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_set_year,
  input  logic [7:0]  in_set_month,
  input  logic [7:0]  in_set_day,
  input  logic [7:0]  in_set_hour,
  input  logic [7:0]  in_set_minute,
  input  logic [7:0]  in_set_second,
  input  logic [7:0]  in_reply_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_bus_command,
  output logic [7:0]  out_bus_data,
  output logic [6:0]  out_second,
  output logic [6:0]  out_minute,
  output logic [5:0]  out_hour,
  output logic [5:0]  out_day,
  output logic [4:0]  out_month,
  output logic [11:0] out_year,
  output logic        out_ok,
  output logic        out_running,
  output logic        out_last
);

  // The front end classifies each request against the pending-read state and
  // folds in all arithmetic (range checks, BCD conversion, report decoding),
  // so a queued job carries everything the back end needs to expand it.
  logic    push;
  logic    can_push;
  job_t    push_job;
  logic    head_valid;
  job_t    head_job;
  logic    pop;
  result_t res;

  assign in_ready = can_push;

  rtcs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .q_ready       (can_push),
    .in_opcode     (in_opcode),
    .in_set_year   (in_set_year),
    .in_set_month  (in_set_month),
    .in_set_day    (in_set_day),
    .in_set_hour   (in_set_hour),
    .in_set_minute (in_set_minute),
    .in_set_second (in_set_second),
    .in_reply_byte (in_reply_byte),
    .push          (push),
    .job           (push_job)
  );

  // The queue lets the front end keep taking requests while the back end is
  // still stepping through a long write sequence or waiting on out_ready.
  rtcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .can_push   (can_push),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // The back end steps a counter across the head job, one result per cycle while
  // out_ready allows, and pops the job together with its last result.
  rtcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_res    (res)
  );

  assign out_kind        = res.kind;
  assign out_bus_command = res.bus_command;
  assign out_bus_data    = res.bus_data;
  assign out_second      = res.second;
  assign out_minute      = res.minute;
  assign out_hour        = res.hour;
  assign out_day         = res.day;
  assign out_month       = res.month;
  assign out_year        = res.year;
  assign out_ok          = res.ok;
  assign out_running     = res.running;
  assign out_last        = res.last;

endmodule

@@ hw/rtl/rtcs_checker.sv @@
module rtcs_checker
  import rtcs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_bus_command,
  input logic [7:0]  out_bus_data,
  input logic [11:0] out_year,
  input logic        out_ok,
  input logic        out_running,
  input logic        out_last
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_bus_command) && $stable(out_bus_data) && $stable(out_last))
    else $error("stalled result changed");

  // A bus read always ends its request and carries a read command.
  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_READ |-> out_last && out_bus_command[0])
    else $error("bus read not final or not a read command");

  // A bus write is always followed by another result and uses a write command.
  a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_WRITE |-> !out_last && !out_bus_command[0])
    else $error("bus write marked final or carries a read command");

  // A time report ends its request and its year is no lower than YEAR_BASE.
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_REPORT |-> out_last && out_year >= YEAR_BASE)
    else $error("time report malformed");

  // Bus transfers carry no status flags.
  a_bus_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_READ || out_kind == K_WRITE) |-> !out_ok && !out_running)
    else $error("status flags set on a bus transfer");

endmodule

bind rtc_time_register_sequencer rtcs_checker u_rtcs_checker (.*);
